/* rtl/spd_pkg.sv */
// ----------------------------------------------------------------------------
// spd_pkg
// shared widths and types for the segment projection distance pipeline
// ----------------------------------------------------------------------------
package spd_pkg;

  localparam int COORD_W    = 24;
  localparam int NORM_W     = 16;
  localparam int NFRAC      = 14;
  localparam int LEN_W      = 26;
  localparam int DIST_W     = 27;
  localparam int RAD_W      = 2 * LEN_W;   // radicand bits that fit an unsaturated root
  localparam int REM_W      = LEN_W + 2;
  localparam int SUM_W      = 68;
  localparam int NCELL      = LEN_W;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // side info that travels alongside the root chain
  typedef struct packed {
    logic vld;
    logic sat_d;
    logic sat_r;
    logic sat_q;
    logic neg_r;
    logic neg_q;
  } tag_t;

endpackage

/* rtl/segment_projection_distances.sv */
// ----------------------------------------------------------------------------
// segment_projection_distances
// segment length and signed endpoint distances to a projected slave point
// ----------------------------------------------------------------------------
// throughput: one word per cycle, busy is always low
// the length and the two distances come from three 26-cell root chains, one root bit per cell
// reset clears the valid bits and the tag pipeline only; results are never held off
module segment_projection_distances
  import spd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_p1_x,
  input  logic signed [COORD_W-1:0] in_p1_y,
  input  logic signed [COORD_W-1:0] in_p1_z,
  input  logic signed [COORD_W-1:0] in_p2_x,
  input  logic signed [COORD_W-1:0] in_p2_y,
  input  logic signed [COORD_W-1:0] in_p2_z,
  input  logic signed [COORD_W-1:0] in_slave_x,
  input  logic signed [COORD_W-1:0] in_slave_y,
  input  logic signed [COORD_W-1:0] in_slave_z,
  input  logic signed [NORM_W-1:0]  in_normal_x,
  input  logic signed [NORM_W-1:0]  in_normal_y,
  input  logic signed [NORM_W-1:0]  in_normal_z,
  output logic                      out_valid,
  output logic [LEN_W-1:0]          out_seg_length,
  output logic signed [DIST_W-1:0]  out_dist_from_first,
  output logic signed [DIST_W-1:0]  out_dist_from_second
);

  assign busy = 1'b0;

  // stage a: input capture
  logic                      va_r;
  logic signed [COORD_W-1:0] p1_a_r [3];
  logic signed [COORD_W-1:0] p2_a_r [3];
  logic signed [COORD_W-1:0] ps_a_r [3];
  logic signed [NORM_W-1:0]  n_a_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= start;
    end
    p1_a_r <= '{in_p1_x, in_p1_y, in_p1_z};
    p2_a_r <= '{in_p2_x, in_p2_y, in_p2_z};
    ps_a_r <= '{in_slave_x, in_slave_y, in_slave_z};
    n_a_r  <= '{in_normal_x, in_normal_y, in_normal_z};
  end

  // stage b: differences and n*s
  logic               vb_r;
  logic signed [24:0] d_b_r  [3];
  logic signed [24:0] s_b_r  [3];
  logic signed [15:0] n_b_r  [3];
  logic signed [40:0] ns_b_r [3];
  logic signed [24:0] d_b_nxt [3];
  logic signed [24:0] s_b_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_b_nxt[i] = 25'(p2_a_r[i]) - 25'(p1_a_r[i]);
      s_b_nxt[i] = 25'(ps_a_r[i]) - 25'(p1_a_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_b_r[i]  <= d_b_nxt[i];
      s_b_r[i]  <= s_b_nxt[i];
      n_b_r[i]  <= n_a_r[i];
      ns_b_r[i] <= 41'(n_a_r[i]) * 41'(s_b_nxt[i]);
    end
  end

  // stage c: dot with the normal, floor shift
  logic               vc_r;
  logic signed [28:0] t_c_r;
  logic signed [24:0] d_c_r [3];
  logic signed [24:0] s_c_r [3];
  logic signed [15:0] n_c_r [3];
  logic signed [42:0] dot_c;

  assign dot_c = 43'(ns_b_r[0]) + 43'(ns_b_r[1]) + 43'(ns_b_r[2]);

  always_ff @(posedge clk) begin
    t_c_r <= dot_c[42:NFRAC];
    d_c_r <= d_b_r;
    s_c_r <= s_b_r;
    n_c_r <= n_b_r;
  end

  // stage d: n*t
  logic               vd_r;
  logic signed [44:0] nt_d_r [3];
  logic signed [24:0] d_d_r  [3];
  logic signed [24:0] s_d_r  [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      nt_d_r[i] <= 45'(n_c_r[i]) * 45'(t_c_r);
    end
    d_d_r <= d_c_r;
    s_d_r <= s_c_r;
  end

  // stage e: r = proj - p1, q = proj - p2
  logic               ve_r;
  logic signed [31:0] r_e_r [3];
  logic signed [32:0] q_e_r [3];
  logic signed [24:0] d_e_r [3];
  logic signed [31:0] r_e_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r_e_nxt[i] = 32'(s_d_r[i]) - 32'($signed(nt_d_r[i][44:NFRAC]));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      r_e_r[i] <= r_e_nxt[i];
      q_e_r[i] <= 33'(r_e_nxt[i]) - 33'(d_d_r[i]);
    end
    d_e_r <= d_d_r;
  end

  // stage f: squares and direction products
  logic               vf_r;
  logic signed [49:0] dd_f_r [3];
  logic signed [63:0] rr_f_r [3];
  logic signed [65:0] qq_f_r [3];
  logic signed [56:0] dr_f_r [3];
  logic signed [57:0] dq_f_r [3];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dd_f_r[i] <= 50'(d_e_r[i]) * 50'(d_e_r[i]);
      rr_f_r[i] <= 64'(r_e_r[i]) * 64'(r_e_r[i]);
      qq_f_r[i] <= 66'(q_e_r[i]) * 66'(q_e_r[i]);
      dr_f_r[i] <= 57'(d_e_r[i]) * 57'(r_e_r[i]);
      dq_f_r[i] <= 58'(d_e_r[i]) * 58'(q_e_r[i]);
    end
  end

  // stage g: sums, saturation and sign
  logic               vg_r;
  logic [SUM_W-1:0]   sd_g, sr_g, sq_g;
  logic signed [58:0] dr_g;
  logic signed [59:0] dq_g;
  logic [RAD_W-1:0]   rad_d_r, rad_r_r, rad_q_r;
  tag_t               tag_g_r;

  always_comb begin
    sd_g = SUM_W'(dd_f_r[0]) + SUM_W'(dd_f_r[1]) + SUM_W'(dd_f_r[2]);
    sr_g = SUM_W'(rr_f_r[0]) + SUM_W'(rr_f_r[1]) + SUM_W'(rr_f_r[2]);
    sq_g = SUM_W'(qq_f_r[0]) + SUM_W'(qq_f_r[1]) + SUM_W'(qq_f_r[2]);
    dr_g = 59'(dr_f_r[0]) + 59'(dr_f_r[1]) + 59'(dr_f_r[2]);
    dq_g = 60'(dq_f_r[0]) + 60'(dq_f_r[1]) + 60'(dq_f_r[2]);
  end

  always_ff @(posedge clk) begin
    rad_d_r       <= sd_g[RAD_W-1:0];
    rad_r_r       <= sr_g[RAD_W-1:0];
    rad_q_r       <= sq_g[RAD_W-1:0];
    tag_g_r.vld   <= vf_r;
    tag_g_r.sat_d <= |sd_g[SUM_W-1:RAD_W];
    tag_g_r.sat_r <= |sr_g[SUM_W-1:RAD_W];
    tag_g_r.sat_q <= |sq_g[SUM_W-1:RAD_W];
    tag_g_r.neg_r <= dr_g[58];
    // back direction from p2 is -d, so its dot is negative when d.q > 0
    tag_g_r.neg_q <= !dq_g[59] && (dq_g != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else begin
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
      vg_r <= vf_r;
    end
  end

  // root chains
  logic [LEN_W-1:0] root_d, root_r, root_q;

  spd_sqrt_chain u_len_d (.clk(clk), .rad(rad_d_r), .root(root_d));
  spd_sqrt_chain u_len_r (.clk(clk), .rad(rad_r_r), .root(root_r));
  spd_sqrt_chain u_len_q (.clk(clk), .rad(rad_q_r), .root(root_q));

  tag_t tag_r [NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCELL; i++) begin
        tag_r[i] <= '0;
      end
    end else begin
      tag_r[0] <= '{vld: vg_r, sat_d: tag_g_r.sat_d, sat_r: tag_g_r.sat_r,
                    sat_q: tag_g_r.sat_q, neg_r: tag_g_r.neg_r, neg_q: tag_g_r.neg_q};
      for (int i = 1; i < NCELL; i++) begin
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  // output word
  logic [LEN_W-1:0]  len_d, len_r, len_q;
  logic [DIST_W-1:0] dist_r_nxt, dist_q_nxt;
  tag_t              tag_o;

  always_comb begin
    tag_o      = tag_r[NCELL-1];
    len_d      = tag_o.sat_d ? LEN_MAX : root_d;
    len_r      = tag_o.sat_r ? LEN_MAX : root_r;
    len_q      = tag_o.sat_q ? LEN_MAX : root_q;
    dist_r_nxt = tag_o.neg_r ? (DIST_W'(0) - DIST_W'(len_r)) : DIST_W'(len_r);
    dist_q_nxt = tag_o.neg_q ? (DIST_W'(0) - DIST_W'(len_q)) : DIST_W'(len_q);
  end

  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tag_o.vld;
    end
    out_seg_length       <= len_d;
    out_dist_from_first  <= dist_r_nxt;
    out_dist_from_second <= dist_q_nxt;
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/spd_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// spd_sqrt_cell
// one root bit per cell: brings in two radicand bits and settles one root bit
// ----------------------------------------------------------------------------
module spd_sqrt_cell
  import spd_pkg::*;
(
  input  logic             clk,
  input  logic [REM_W-1:0] rem_in,
  input  logic [LEN_W-1:0] root_in,
  input  logic [RAD_W-1:0] rad_in,
  output logic [REM_W-1:0] rem_r,
  output logic [LEN_W-1:0] root_r,
  output logic [RAD_W-1:0] rad_r
);

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             take;
  logic [REM_W+1:0] diff;
  logic [REM_W-1:0] rem_nxt;
  logic [LEN_W-1:0] root_nxt;
  logic [RAD_W-1:0] rad_nxt;

  always_comb begin
    rem_sh   = {rem_in, rad_in[RAD_W-1 -: 2]};
    trial    = {2'b00, root_in, 2'b01};
    take     = (rem_sh >= trial);
    diff     = rem_sh - trial;
    rem_nxt  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    root_nxt = {root_in[LEN_W-2:0], take};
    rad_nxt  = {rad_in[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= rad_nxt;
  end

endmodule

/* rtl/spd_sqrt_chain.sv */
// ----------------------------------------------------------------------------
// spd_sqrt_chain
// row of root cells, a new radicand enters every cycle
// ----------------------------------------------------------------------------
module spd_sqrt_chain
  import spd_pkg::*;
(
  input  logic             clk,
  input  logic [RAD_W-1:0] rad,
  output logic [LEN_W-1:0] root
);

  logic [REM_W-1:0] rem_a  [NCELL+1];
  logic [LEN_W-1:0] root_a [NCELL+1];
  logic [RAD_W-1:0] rad_a  [NCELL+1];

  assign rem_a[0]  = '0;
  assign root_a[0] = '0;
  assign rad_a[0]  = rad;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    spd_sqrt_cell u_cell (
      .clk     (clk),
      .rem_in  (rem_a[i]),
      .root_in (root_a[i]),
      .rad_in  (rad_a[i]),
      .rem_r   (rem_a[i+1]),
      .root_r  (root_a[i+1]),
      .rad_r   (rad_a[i+1])
    );
  end

  assign root = root_a[NCELL];

endmodule

/* bench/segment_distance_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_distance_checker
// watches the command and result ports, predicts the length and the two
// signed endpoint distances of every accepted word and compares in order
// ----------------------------------------------------------------------------
module segment_distance_checker
  import spd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [COORD_W-1:0] p1_x,
  input  logic signed [COORD_W-1:0] p1_y,
  input  logic signed [COORD_W-1:0] p1_z,
  input  logic signed [COORD_W-1:0] p2_x,
  input  logic signed [COORD_W-1:0] p2_y,
  input  logic signed [COORD_W-1:0] p2_z,
  input  logic signed [COORD_W-1:0] slave_x,
  input  logic signed [COORD_W-1:0] slave_y,
  input  logic signed [COORD_W-1:0] slave_z,
  input  logic signed [NORM_W-1:0]  normal_x,
  input  logic signed [NORM_W-1:0]  normal_y,
  input  logic signed [NORM_W-1:0]  normal_z,
  input  logic                      out_valid,
  input  logic [LEN_W-1:0]          out_seg_length,
  input  logic signed [DIST_W-1:0]  out_dist_from_first,
  input  logic signed [DIST_W-1:0]  out_dist_from_second,
  output int                        fails,
  output int                        pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [LEN_W-1:0]  seg_length;
    logic [DIST_W-1:0] dist_first;
    logic [DIST_W-1:0] dist_second;
  } distances_t;

  distances_t expected_distances[$];

  function automatic logic [63:0] floor_root(wide_t n);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = r | (64'd1 << b);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (sq <= n) r = cand;
    end
    return r;
  endfunction

  // root of the squared length, clipped to the output range
  function automatic logic [LEN_W-1:0] clipped_length(wide_t a, wide_t b, wide_t c);
    logic [63:0] root;
    root = floor_root(a * a + b * b + c * c);
    return (root > {38'd0, LEN_MAX}) ? LEN_MAX : root[LEN_W-1:0];
  endfunction

  function automatic logic [DIST_W-1:0] signed_distance(logic [LEN_W-1:0] m, logic neg);
    logic [DIST_W-1:0] v;
    v = {1'b0, m};
    return neg ? (~v + 1'b1) : v;
  endfunction

  function automatic distances_t predict_distances();
    wide_t      a1 [3];
    wide_t      a2 [3];
    wide_t      sp [3];
    wide_t      nv [3];
    wide_t      d  [3];
    wide_t      s  [3];
    wide_t      r  [3];
    wide_t      q  [3];
    wide_t      dot, t, dr, dq;
    distances_t res;
    a1 = '{p1_x, p1_y, p1_z};
    a2 = '{p2_x, p2_y, p2_z};
    sp = '{slave_x, slave_y, slave_z};
    nv = '{normal_x, normal_y, normal_z};
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      d[i] = a2[i] - a1[i];
      s[i] = sp[i] - a1[i];
      dot += nv[i] * s[i];
    end
    t  = dot >>> NFRAC;
    dr = 0;
    dq = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = s[i] - ((nv[i] * t) >>> NFRAC);
      q[i] = r[i] - d[i];
      dr += d[i] * r[i];
      dq -= d[i] * q[i];
    end
    res.seg_length  = clipped_length(d[0], d[1], d[2]);
    res.dist_first  = signed_distance(clipped_length(r[0], r[1], r[2]), dr < 0);
    res.dist_second = signed_distance(clipped_length(q[0], q[1], q[2]), dq < 0);
    return res;
  endfunction

  initial fails = 0;
  assign pending = expected_distances.size();

  always @(posedge clk) begin
    distances_t exp_d;
    if (rst_n && start && !busy) begin
      expected_distances.insert(expected_distances.size(), predict_distances());
    end
    if (rst_n && out_valid) begin
      if (expected_distances.size() == 0) begin
        $error("result word with nothing expected");
        fails++;
      end else begin
        exp_d = expected_distances.pop_front();
        if (out_seg_length !== exp_d.seg_length) begin
          $error("seg_length expected %0d got %0d", exp_d.seg_length, out_seg_length);
          fails++;
        end
        if (out_dist_from_first !== exp_d.dist_first) begin
          $error("dist_from_first expected %0d got %0d",
                 $signed(exp_d.dist_first), out_dist_from_first);
          fails++;
        end
        if (out_dist_from_second !== exp_d.dist_second) begin
          $error("dist_from_second expected %0d got %0d",
                 $signed(exp_d.dist_second), out_dist_from_second);
          fails++;
        end
      end
    end
  end

endmodule

/* bench/segment_projection_distances_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_projection_distances_tb
// drives directed and random segment/point/normal words with random gaps and
// lets the checker compare every result word against its own prediction
// ----------------------------------------------------------------------------
module segment_projection_distances_tb;
  import spd_pkg::*;

  localparam int N_RANDOM   = 1330;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [NORM_W-1:0]  normc_t;

  localparam coord_t CMAX = 24'sh7FFFFF;
  localparam coord_t CMIN = 24'sh800000;
  localparam normc_t NONE = 16'sd16384;

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, sl_x, sl_y, sl_z;
  normc_t n_x, n_y, n_z;
  logic                     out_valid;
  logic [LEN_W-1:0]         out_seg_length;
  logic signed [DIST_W-1:0] out_dist_from_first;
  logic signed [DIST_W-1:0] out_dist_from_second;
  int fails;
  int pending;
  int cycles;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("segment_projection_distances_tb NOT OK");
        $finish;
      end
    end
  end

  segment_projection_distances u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_p1_x(p1_x), .in_p1_y(p1_y), .in_p1_z(p1_z),
    .in_p2_x(p2_x), .in_p2_y(p2_y), .in_p2_z(p2_z),
    .in_slave_x(sl_x), .in_slave_y(sl_y), .in_slave_z(sl_z),
    .in_normal_x(n_x), .in_normal_y(n_y), .in_normal_z(n_z),
    .out_valid(out_valid), .out_seg_length(out_seg_length),
    .out_dist_from_first(out_dist_from_first),
    .out_dist_from_second(out_dist_from_second)
  );

  segment_distance_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
    .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
    .slave_x(sl_x), .slave_y(sl_y), .slave_z(sl_z),
    .normal_x(n_x), .normal_y(n_y), .normal_z(n_z),
    .out_valid(out_valid), .out_seg_length(out_seg_length),
    .out_dist_from_first(out_dist_from_first),
    .out_dist_from_second(out_dist_from_second),
    .fails(fails), .pending(pending)
  );

  // called at a falling edge; returns at the falling edge after acceptance, or after the random gap that follows it
  task automatic send_word(coord_t ax, coord_t ay, coord_t az, coord_t bx, coord_t by,
                           coord_t bz, coord_t sx, coord_t sy, coord_t sz,
                           normc_t nx, normc_t ny, normc_t nz);
    bit ok;
    int gap;
    int sel;
    p1_x = ax; p1_y = ay; p1_z = az;
    p2_x = bx; p2_y = by; p2_z = bz;
    sl_x = sx; sl_y = sy; sl_z = sz;
    n_x = nx; n_y = ny; n_z = nz;
    start = 1'b1;
    // busy only moves at a rising edge, so its value here holds through the next one
    forever begin
      ok = !busy;
      @(negedge clk);
      if (ok) break;
    end
    sel = $urandom_range(0, 19);
    if (no_gaps || sel < 12) gap = 0;
    else if (sel < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic coord_t rand_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return coord_t'($urandom);
    if (sel < 8) return coord_t'($signed($urandom_range(0, 65535)) - 32768);
    if (sel == 8) return CMAX;
    return CMIN;
  endfunction

  function automatic normc_t rand_normal();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return normc_t'($signed($urandom_range(0, 32768)) - 16384);
    if (sel < 8) return ($urandom_range(0, 1) != 0) ? NONE : -NONE;
    if (sel == 8) return normc_t'($urandom);
    return '0;
  endfunction

  initial begin
    coord_t ax, ay, az, bx, by, bz;
    normc_t nx, ny, nz;
    int sel;
    rst_n = 1'b0;
    start = 1'b0;
    no_gaps = 1'b0;
    {p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, sl_x, sl_y, sl_z} = '0;
    {n_x, n_y, n_z} = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // all zero, then a degenerate segment
    send_word('0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_word(24'sd100, -24'sd200, 24'sd300, 24'sd100, -24'sd200, 24'sd300,
              24'sd5000, 24'sd7, -24'sd9, NONE, '0, '0);
    // plain unit-normal cases along each axis
    send_word('0, '0, '0, 24'sd4096, '0, '0, 24'sd2048, 24'sd999, '0, '0, NONE, '0);
    send_word('0, '0, '0, '0, 24'sd4096, '0, 24'sd777, 24'sd5000, 24'sd300,
              '0, '0, -NONE);
    send_word('0, '0, '0, '0, '0, 24'sd4096, -24'sd100, 24'sd50, -24'sd3000,
              NONE, '0, '0);
    // projection exactly on an endpoint: zero dot product
    send_word(24'sd10, 24'sd20, 24'sd30, 24'sd4106, 24'sd20, 24'sd30,
              24'sd10, 24'sd20, 24'sd5030, '0, '0, NONE);
    // field extremes
    send_word(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, NONE, NONE, NONE);
    send_word(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMAX, CMIN, -NONE, -NONE, -NONE);
    send_word(CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMIN,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    // oversized normal patterns push the distances into saturation
    send_word(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
              16'sh8000, 16'sh8000, 16'sh8000);
    send_word(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
              16'sh8000, 16'sh7FFF, 16'sh8000);
    send_word(CMIN, '0, CMAX, CMAX, '0, CMIN, CMAX, CMIN, '0, 16'sh7FFF, 16'sh8000, '0);
    send_word('0, '0, '0, '0, '0, '0, CMAX, CMAX, CMAX, '0, '0, '0);
    send_word(-24'sd1, -24'sd1, -24'sd1, 24'sd1, 24'sd1, 24'sd1, -24'sd1, 24'sd1, '0,
              -16'sd1, 16'sd1, -16'sd1);

    for (int i = 0; i < N_RANDOM; i++) begin
      no_gaps = (i % 300) > 240;
      ax = rand_coord(); ay = rand_coord(); az = rand_coord();
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        bx = ax; by = ay; bz = az;
      end else begin
        bx = rand_coord(); by = rand_coord(); bz = rand_coord();
      end
      sel = $urandom_range(0, 9);
      if (sel < 3) begin
        // axis-aligned unit normal
        {nx, ny, nz} = '0;
        case ($urandom_range(0, 2))
          0: nx = ($urandom_range(0, 1) != 0) ? NONE : -NONE;
          1: ny = ($urandom_range(0, 1) != 0) ? NONE : -NONE;
          default: nz = ($urandom_range(0, 1) != 0) ? NONE : -NONE;
        endcase
      end else begin
        nx = rand_normal(); ny = rand_normal(); nz = rand_normal();
      end
      send_word(ax, ay, az, bx, by, bz, rand_coord(), rand_coord(), rand_coord(),
                nx, ny, nz);
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fails == 0) begin
      $display("segment_projection_distances_tb OK");
    end else begin
      $display("segment_projection_distances_tb NOT OK");
    end
    $finish;
  end

endmodule

/* segment_projection_distances.f */
rtl/spd_pkg.sv
rtl/spd_sqrt_cell.sv
rtl/spd_sqrt_chain.sv
rtl/segment_projection_distances.sv
bench/segment_distance_checker.sv
bench/segment_projection_distances_tb.sv
